@@ design/btmx_pkg.sv @@
// Package for the binary trie maximum-xor block.
// Holds the default sizes, request and status codes, and the sequencer states.
// No dependencies.
package btmx_pkg;

	localparam int KEY_BITS_DEF  = 32;
	localparam int NODE_CAP_DEF  = 32768;

	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_QUERY  = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_CHECK = 6'b000100,
		S_ALLOC = 6'b001000,
		S_LEAF  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

endpackage

@@ design/binary_trie_max_xor.sv @@
// Binary trie of keys answering maximum-xor queries, with a node memory.
// Depends on btmx_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries one request of func and
// key_value; the output channel (out_valid/out_ready) returns one result of
// best_xor, running_max and status for every request. Only the low KEY_BITS
// bits of key_value are used.
// Insert walks the trie from the most significant key bit, one node memory
// read per level, then allocates the missing nodes with one memory write per
// level plus one write for the leaf. Query walks one level per cycle, taking
// the branch opposite to the value bit where it exists. The single read port
// of the node memory sets the pace of both walks.
// One request is in work at a time; in_ready is high only while idle.
// The result sits in an output register, so a new request can be taken while
// the previous result waits; a stalled receiver holds the block only when a
// second result is ready. Reset empties the trie (root preallocated, first
// free node is 1) and zeroes the running maximum; the node memory itself needs
// no clearing, since every node is written when it is allocated.
module binary_trie_max_xor
	import btmx_pkg::*;
#(
	parameter int KEY_BITS      = KEY_BITS_DEF,
	parameter int NODE_CAPACITY = NODE_CAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [DATA_W-1:0]   key_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   best_xor,
	output logic [DATA_W-1:0]   running_max,
	output logic [STATUS_W-1:0] status
);

	localparam int NODE_W = $clog2(NODE_CAPACITY);
	localparam int LINK_W = 2 * NODE_W;
	localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
	localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	state_t                state_q;
	func_t                 func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [LVL_W-1:0]      pos_q;
	logic [NODE_W-1:0]     node_q;
	logic [LINK_W-1:0]     links_q;
	logic [LINK_W-1:0]     root_q;
	logic [CNT_W-1:0]      free_q;
	logic [KEY_BITS-1:0]   acc_q;
	logic [KEY_BITS-1:0]   best_q;
	status_t               status_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     best_xor_q;
	logic [DATA_W-1:0]     running_max_q;
	logic [STATUS_W-1:0]   status_out_q;

	logic [LINK_W-1:0]     mem [NODE_CAPACITY];
	logic [LINK_W-1:0]     rd_q;

	logic [LINK_W-1:0]     cur_links;
	logic [NODE_W-1:0]     child0;
	logic [NODE_W-1:0]     child1;
	logic                  cur_bit;
	logic [NODE_W-1:0]     same_child;
	logic [NODE_W-1:0]     opp_child;
	logic [NODE_W-1:0]     next_node;
	logic [NODE_W-1:0]     free_idx;
	logic [LINK_W-1:0]     new_links;
	logic [LVL_W:0]        need;
	logic [CNT_W:0]        need_sum;
	logic                  store_full;
	logic                  mem_we;
	logic [NODE_W-1:0]     mem_waddr;
	logic [LINK_W-1:0]     mem_wdata;
	logic                  take_max;
	logic                  accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// The root links live in a register; every other node comes from memory.
	assign cur_links  = (node_q == '0) ? root_q : rd_q;
	assign child0     = cur_links[NODE_W-1:0];
	assign child1     = cur_links[LINK_W-1:NODE_W];
	assign cur_bit    = key_q[pos_q];
	assign same_child = cur_bit ? child1 : child0;
	assign opp_child  = cur_bit ? child0 : child1;
	assign next_node  = (func_q == FN_QUERY && opp_child != '0) ? opp_child : same_child;

	assign free_idx   = free_q[NODE_W-1:0];
	assign new_links  = cur_bit ? {free_idx, links_q[NODE_W-1:0]}
	                            : {links_q[LINK_W-1:NODE_W], free_idx};

	assign need       = {1'b0, pos_q} + (LVL_W+1)'(1);
	assign need_sum   = {1'b0, free_q} + (CNT_W+1)'(need);
	assign store_full = need_sum > (CNT_W+1)'(NODE_CAPACITY);

	assign take_max   = (func_q == FN_QUERY) && (status_q == ST_OK) && (acc_q > best_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = '0;
		if (state_q == S_ALLOC && node_q != '0) begin
			mem_we    = 1'b1;
			mem_wdata = new_links;
		end else if (state_q == S_LEAF) begin
			mem_we    = 1'b1;
		end
	end

	// Node memory: one write port, one registered read port that follows the walk.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[next_node];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			func_q        <= FN_INSERT;
			key_q         <= '0;
			pos_q         <= '0;
			node_q        <= '0;
			links_q       <= '0;
			root_q        <= '0;
			free_q        <= CNT_W'(1);
			acc_q         <= '0;
			best_q        <= '0;
			status_q      <= ST_OK;
			out_valid_q   <= 1'b0;
			best_xor_q    <= '0;
			running_max_q <= '0;
			status_out_q  <= '0;
		end else begin
			// When the next result is finishing, S_FIN refills the register instead.
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= func_t'(func);
						key_q    <= key_value[KEY_BITS-1:0];
						pos_q    <= LVL_W'(KEY_BITS - 1);
						node_q   <= '0;
						acc_q    <= '0;
						status_q <= ST_OK;
						unique case (func_t'(func))
							FN_INSERT: state_q <= S_WALK;
							FN_QUERY: begin
								if (root_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									state_q  <= S_WALK;
								end
							end
							FN_CLEAR: begin
								free_q  <= CNT_W'(1);
								root_q  <= '0;
								best_q  <= '0;
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_WALK: begin
					if (func_q == FN_QUERY) begin
						if (opp_child != '0) begin
							acc_q[pos_q] <= 1'b1;
						end
						node_q <= next_node;
						// A node with no child at all ends the walk early.
						if (pos_q == '0 || next_node == '0) begin
							state_q <= S_FIN;
						end else begin
							pos_q <= pos_q - LVL_W'(1);
						end
					end else if (same_child == '0) begin
						links_q <= cur_links;
						state_q <= S_CHECK;
					end else begin
						node_q <= same_child;
						if (pos_q == '0) begin
							state_q <= S_FIN;
						end else begin
							pos_q <= pos_q - LVL_W'(1);
						end
					end
				end
				S_CHECK: begin
					if (store_full) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						state_q  <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					// Link the current node to a fresh one; the fresh node starts empty.
					if (node_q == '0) begin
						root_q <= new_links;
					end
					node_q  <= free_idx;
					links_q <= '0;
					free_q  <= free_q + CNT_W'(1);
					if (pos_q == '0) begin
						state_q <= S_LEAF;
					end else begin
						pos_q <= pos_q - LVL_W'(1);
					end
				end
				S_LEAF: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						best_xor_q    <= DATA_W'(acc_q);
						status_out_q  <= status_q;
						if (take_max) begin
							best_q        <= acc_q;
							running_max_q <= DATA_W'(acc_q);
						end else begin
							running_max_q <= DATA_W'(best_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign best_xor    = best_xor_q;
	assign running_max = running_max_q;
	assign status      = status_out_q;

	// The free pointer never passes the store and never reaches the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		(free_q != '0) && (free_q <= CNT_W'(NODE_CAPACITY)))
		else $error("free node pointer out of range");

	// Allocation only happens after the capacity check has passed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> (free_q < CNT_W'(NODE_CAPACITY)))
		else $error("allocation beyond node store");

	// A result never exceeds the running maximum reported with it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (running_max_q >= best_xor_q))
		else $error("running maximum below result");

	// A refused insert leaves the trie untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && store_full) |=> ($stable(root_q) && $stable(free_q)))
		else $error("refused insert changed the trie");

endmodule

@@ sim/btmx_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for binary_trie_max_xor: watches the request and result channels,
// keeps its own trie to predict every result and compares it field by field.
// Depends on btmx_pkg.
module btmx_checker
	import btmx_pkg::*;
#(
	parameter int KEY_BITS      = KEY_BITS_DEF,
	parameter int NODE_CAPACITY = NODE_CAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [DATA_W-1:0]   key_value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [DATA_W-1:0]   best_xor,
	input  logic [DATA_W-1:0]   running_max,
	input  logic [STATUS_W-1:0] status,
	output int unsigned         fail_count,
	output int unsigned         pending
);

	localparam int IDX_W = $clog2(NODE_CAPACITY);

	typedef struct packed {
		logic [DATA_W-1:0] xr;
		logic [DATA_W-1:0] peak;
		status_t           st;
	} outcome_t;

	// Two child indices per node. Node 0 is the root, so index 0 means no child.
	logic [IDX_W-1:0]  kid [0:NODE_CAPACITY-1][0:1];
	int                free_node;
	logic [DATA_W-1:0] peak_xor;
	outcome_t          outcome_q [$];

	function automatic outcome_t trie_outcome(func_t op, logic [DATA_W-1:0] raw);
		outcome_t          r;
		logic [DATA_W-1:0] v;
		int                node;
		int                lvl;
		logic              b;
		logic              walking;
		v = raw & ((DATA_W'(1) << KEY_BITS) - 1);
		r.xr = '0;
		r.st = ST_OK;
		case (op)
			FN_INSERT: begin
				node = 0;
				lvl = 0;
				while (lvl < KEY_BITS && kid[node][v[KEY_BITS-1-lvl]] != 0) begin
					node = kid[node][v[KEY_BITS-1-lvl]];
					lvl++;
				end
				// The whole missing tail must fit, or nothing is allocated.
				if (lvl < KEY_BITS && free_node + (KEY_BITS - lvl) > NODE_CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					while (lvl < KEY_BITS) begin
						b = v[KEY_BITS-1-lvl];
						kid[free_node][0] = '0;
						kid[free_node][1] = '0;
						kid[node][b] = IDX_W'(free_node);
						node = free_node;
						free_node++;
						lvl++;
					end
				end
			end
			FN_QUERY: begin
				if (kid[0][0] == 0 && kid[0][1] == 0) begin
					r.st = ST_EMPTY;
				end else begin
					node = 0;
					lvl = 0;
					walking = 1'b1;
					while (walking && lvl < KEY_BITS) begin
						b = v[KEY_BITS-1-lvl];
						if (kid[node][!b] != 0) begin
							r.xr[KEY_BITS-1-lvl] = 1'b1;
							node = kid[node][!b];
						end else if (kid[node][b] != 0) begin
							node = kid[node][b];
						end else begin
							walking = 1'b0;
						end
						lvl++;
					end
					if (r.xr > peak_xor)
						peak_xor = r.xr;
				end
			end
			FN_CLEAR: begin
				free_node = 1;
				kid[0][0] = '0;
				kid[0][1] = '0;
				peak_xor = '0;
			end
			default: ;
		endcase
		r.peak = peak_xor;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t    want;
		int unsigned errs;
		if (!arst_n) begin
			free_node = 1;
			kid[0][0] = '0;
			kid[0][1] = '0;
			peak_xor = '0;
			outcome_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (in_valid && in_ready)
				outcome_q.push_back(trie_outcome(func_t'(func), key_value));
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding: best_xor %0h", best_xor);
					errs++;
				end else begin
					want = outcome_q.pop_front();
					if (best_xor !== want.xr) begin
						$error("best_xor: expected %0h, actual %0h", want.xr, best_xor);
						errs++;
					end
					if (running_max !== want.peak) begin
						$error("running_max: expected %0h, actual %0h", want.peak, running_max);
						errs++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= outcome_q.size();
		end
	end

endmodule

@@ sim/tb_binary_trie_max_xor.sv @@
`timescale 1ns / 1ps
// Top of the binary_trie_max_xor testbench: clock, reset, request stimulus and
// result back-pressure, with btmx_checker doing all prediction and comparison.
// Depends on btmx_pkg, binary_trie_max_xor and btmx_checker.
module tb_binary_trie_max_xor;
	import btmx_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [FUNC_W-1:0]   func;
	logic [DATA_W-1:0]   key_value;
	logic                out_valid;
	logic                out_ready;
	logic [DATA_W-1:0]   best_xor;
	logic [DATA_W-1:0]   running_max;
	logic [STATUS_W-1:0] status;
	int unsigned         fail_count;
	int unsigned         pending;

	int unsigned       accepted = 0;
	int unsigned       tx_idle_pct = 9;
	int unsigned       rx_idle_pct = 77;
	logic [DATA_W-1:0] last_key = '0;

	binary_trie_max_xor DUT (.*);

	btmx_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// Offers one request and returns at the edge where it is taken.
	task automatic offer(func_t op, logic [DATA_W-1:0] v);
		if (accepted < 580) begin
			tx_idle_pct = 9;
			rx_idle_pct = 77;
		end else if (accepted < 1160) begin
			tx_idle_pct = 77;
			rx_idle_pct = 9;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= op;
		key_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accepted++;
	endtask

	function automatic func_t pick_op();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 2)
			return FN_CLEAR;
		if (r < 5)
			return FN_NONE;
		if (r < 50)
			return FN_INSERT;
		return FN_QUERY;
	endfunction

	// Values near the last inserted key drive queries down long shared paths.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return last_key ^ (DATA_W'(1) << $urandom_range(DATA_W - 1));
			4: return DATA_W'($urandom_range(255));
			default: return DATA_W'($urandom());
		endcase
	endfunction

	task automatic random_requests(int unsigned count);
		func_t             op;
		logic [DATA_W-1:0] v;
		repeat (count) begin
			op = pick_op();
			v = pick_value();
			if (op == FN_INSERT)
				last_key = v;
			offer(op, v);
		end
	endtask

	initial begin
		logic [DATA_W-1:0] v;
		logic [10:0]       pfx;
		int                i;
		int                b;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		func      <= FN_INSERT;
		key_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(FN_QUERY, 32'h0000_0000);
		offer(FN_NONE, 32'hFFFF_FFFF);
		offer(FN_INSERT, 32'h0000_0000);
		offer(FN_INSERT, 32'hFFFF_FFFF);
		offer(FN_INSERT, 32'hFFFF_FFFF);
		offer(FN_QUERY, 32'h0000_0000);
		offer(FN_QUERY, 32'hFFFF_FFFF);
		offer(FN_QUERY, 32'hA5A5_A5A5);
		offer(FN_CLEAR, 32'hFFFF_FFFF);
		offer(FN_QUERY, 32'h1234_5678);
		offer(FN_INSERT, 32'h8000_0000);
		offer(FN_INSERT, 32'h0000_0001);
		offer(FN_QUERY, 32'h8000_0001);
		offer(FN_QUERY, 32'h7FFF_FFFF);
		offer(FN_NONE, 32'h0000_0000);
		offer(FN_INSERT, 32'h5555_5555);
		offer(FN_QUERY, 32'hAAAA_AAAA);
		offer(FN_CLEAR, 32'h0000_0000);

		random_requests(200);

		// Fill the node store: bit-reversed prefixes make keys part ways near the
		// root, so each insert allocates nearly a full path and the store runs out.
		offer(FN_CLEAR, '0);
		for (i = 0; i < 1420; i++) begin
			if ($urandom_range(15) == 0)
				offer(FN_QUERY, DATA_W'($urandom()));
			for (b = 0; b < 11; b++)
				pfx[b] = i[10-b];
			v = {pfx, 21'($urandom())};
			last_key = v;
			offer(FN_INSERT, v);
		end
		// Keys that branch off deep in the trie need only a few nodes each.
		repeat (12)
			offer(FN_INSERT, last_key ^ DATA_W'($urandom_range(7)));
		offer(FN_INSERT, last_key);
		offer(FN_INSERT, DATA_W'($urandom()));
		repeat (4)
			offer(FN_QUERY, DATA_W'($urandom()));
		offer(FN_CLEAR, '0);
		random_requests(20);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && accepted >= 100) begin
				// Hold results back long enough that the block stops taking requests.
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

endmodule

@@ files.f @@
design/btmx_pkg.sv
design/binary_trie_max_xor.sv
sim/btmx_checker.sv
sim/tb_binary_trie_max_xor.sv
